// ----- rtl/cvu_pkg.sv -----
// Shared constants and elaboration-time helpers for the CORDIC vectoring unit.
`default_nettype none

package cvu_pkg;

  // Reset value of the inverse gain register, 1/K in Q0.16
  localparam logic [15:0] INV_GAIN_RST = 16'd39797;

  // Width of the inverse gain register and of its fraction
  localparam int unsigned GAIN_W = 16;

  // atan(2^-i) with pi = 2^31
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Step angle of iteration idx, rounded half up to an aw-bit angle scale
  function automatic logic [31:0] step_angle(input int unsigned idx, input int unsigned aw);
    logic [32:0]  t;
    int unsigned  s;
    t = {1'b0, ATAN_TAB[idx % 32]};
    s = 32 - aw;
    if (s != 0) begin
      t = (t + (33'd1 << (s - 1))) >> s;
    end
    return t[31:0];
  endfunction

  // ceil(sqrt(2^(2w-1))): upper clamp of the magnitude output
  function automatic logic [63:0] mag_limit(input int unsigned w);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] c;
    n = 64'd1 << (2 * w - 1);
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) begin
        r = c;
      end
    end
    if (r * r < n) begin
      r = r + 64'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cvu_rot_stage.sv -----
// One registered CORDIC micro-rotation, steered by the sign of y.
`default_nettype none

module cvu_rot_stage #(
  parameter int unsigned         IW      = 19,
  parameter int unsigned         ANGLE_W = 16,
  parameter int unsigned         SHIFT   = 0,
  parameter logic [ANGLE_W-1:0]  STEP    = '0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire                      valid_i,
  input  wire  signed [IW-1:0]     x_i,
  input  wire  signed [IW-1:0]     y_i,
  input  wire  [ANGLE_W-1:0]       z_i,
  output logic                     valid_o,
  output logic signed [IW-1:0]     x_o,
  output logic signed [IW-1:0]     y_o,
  output logic [ANGLE_W-1:0]       z_o
);

  logic                  valid_q;
  logic signed [IW-1:0]  x_d, x_q;
  logic signed [IW-1:0]  y_d, y_q;
  logic [ANGLE_W-1:0]    z_d, z_q;
  logic signed [IW-1:0]  xs, ys;

  // floor shifts of both components
  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  // rotate toward the x axis; no rotation when y is zero
  always_comb begin
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (y_i[IW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - STEP;
    end else if (y_i != '0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + STEP;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

`default_nettype wire

// ----- rtl/cordic_vectoring_unit.sv -----
// Pipelined circular CORDIC in vectoring mode with gain compensation.
//
//  channel   dir  fields (low bit first)                   accepted when
//  s_axis    in   vec_x, vec_y, angle_in                   tvalid && tready
//  m_axis    out  magnitude, residual_y, angle_out         tvalid && tready
//  cfg       in   inv_gain (Q0.16)                         cfg_we_i
//
// One vector enters per cycle while s_axis_tready is high. Its path to m_axis:
// quadrant fold, one stage per micro-rotation, gain multiply, rounding and
// clamp, output register. A two-entry output register and skid buffer hold
// results while m_axis stalls; s_axis_tready drops only when the skid is full,
// and then the whole pipeline holds. Reset clears valid bits and loads inv_gain.
`default_nettype none

module cordic_vectoring_unit #(
  parameter int unsigned ITERATIONS = 16,
  parameter int unsigned DATA_W     = 16,
  parameter int unsigned ANGLE_W    = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // vec_x, vec_y, angle_in; zero padded to bytes
  input  wire  [((2*DATA_W+ANGLE_W+7)/8)*8-1:0] s_axis_tdata,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // magnitude, residual_y, angle_out; zero padded to bytes
  output logic [((2*DATA_W+ANGLE_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  input  wire                                cfg_we_i,
  input  wire  [cvu_pkg::GAIN_W-1:0]         cfg_wdata_i
);

  import cvu_pkg::*;

  localparam int unsigned BUS_W = ((2 * DATA_W + ANGLE_W + 7) / 8) * 8;
  localparam int unsigned PAY_W = 2 * DATA_W + ANGLE_W;
  localparam int unsigned IW    = DATA_W + 3;       // room for CORDIC growth
  localparam int unsigned PW    = IW + GAIN_W + 1;  // product width
  localparam int unsigned SW    = PW - GAIN_W + 1;  // rounded, before clamp
  localparam logic [ANGLE_W-1:0] QUARTER = ANGLE_W'(1) << (ANGLE_W - 2);
  localparam logic signed [SW-1:0] MAG_MAX = SW'(mag_limit(DATA_W));
  localparam logic signed [SW-1:0] RES_MAX = SW'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam logic signed [SW-1:0] RES_MIN = -RES_MAX - SW'(1);

  logic                  en;
  logic [GAIN_W-1:0]     inv_gain_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_gain_q <= INV_GAIN_RST;
    end else if (cfg_we_i) begin
      inv_gain_q <= cfg_wdata_i;
    end
  end

  // pipeline advances unless the skid stage holds a result
  logic skid_valid_q;
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // unpack input
  logic signed [DATA_W-1:0] in_x, in_y;
  logic [ANGLE_W-1:0]       in_z;
  assign in_x = s_axis_tdata[DATA_W-1:0];
  assign in_y = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign in_z = s_axis_tdata[PAY_W-1:2*DATA_W];

  // quadrant fold: negative x turns by -pi/2 (y >= 0) or +pi/2 (y < 0)
  logic signed [IW-1:0] ext_x, ext_y, fx_d, fy_d;
  logic [ANGLE_W-1:0]   fz_d;
  assign ext_x = IW'(in_x);
  assign ext_y = IW'(in_y);

  always_comb begin
    fx_d = ext_x;
    fy_d = ext_y;
    fz_d = in_z;
    if (in_x[DATA_W-1]) begin
      if (!in_y[DATA_W-1]) begin
        fx_d = ext_y;
        fy_d = -ext_x;
        fz_d = in_z + QUARTER;
      end else begin
        fx_d = -ext_y;
        fy_d = ext_x;
        fz_d = in_z - QUARTER;
      end
    end
  end

  logic                 vp   [ITERATIONS+1];
  logic signed [IW-1:0] xp   [ITERATIONS+1];
  logic signed [IW-1:0] yp   [ITERATIONS+1];
  logic [ANGLE_W-1:0]   zp   [ITERATIONS+1];
  logic                 fold_valid_q;
  logic signed [IW-1:0] fold_x_q, fold_y_q;
  logic [ANGLE_W-1:0]   fold_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else if (en) begin
      fold_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fold_x_q <= fx_d;
      fold_y_q <= fy_d;
      fold_z_q <= fz_d;
    end
  end

  assign vp[0] = fold_valid_q;
  assign xp[0] = fold_x_q;
  assign yp[0] = fold_y_q;
  assign zp[0] = fold_z_q;

  // micro-rotation stages
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
    cvu_rot_stage #(
      .IW      (IW),
      .ANGLE_W (ANGLE_W),
      .SHIFT   (k),
      .STEP    (ANGLE_W'(step_angle(k, ANGLE_W)))
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vp[k]),
      .x_i     (xp[k]),
      .y_i     (yp[k]),
      .z_i     (zp[k]),
      .valid_o (vp[k+1]),
      .x_o     (xp[k+1]),
      .y_o     (yp[k+1]),
      .z_o     (zp[k+1])
    );
  end

  // gain multiply
  logic signed [PW-1:0] gain_ext, px_d, py_d, px_q, py_q;
  logic [ANGLE_W-1:0]   mz_q;
  logic                 mvalid_q;
  assign gain_ext = signed'({{(PW - GAIN_W){1'b0}}, inv_gain_q});
  assign px_d     = PW'(xp[ITERATIONS]) * gain_ext;
  assign py_d     = PW'(yp[ITERATIONS]) * gain_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else if (en) begin
      mvalid_q <= vp[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= px_d;
      py_q <= py_d;
      mz_q <= zp[ITERATIONS];
    end
  end

  // round half up, then clamp
  logic signed [PW:0]      rx, ry;
  logic signed [SW-1:0]    sx, sy;
  logic [DATA_W-1:0]       mag_d, res_d;
  assign rx = (PW+1)'(px_q) + (PW+1)'(1 << (GAIN_W - 1));
  assign ry = (PW+1)'(py_q) + (PW+1)'(1 << (GAIN_W - 1));
  assign sx = rx[PW:GAIN_W];
  assign sy = ry[PW:GAIN_W];

  always_comb begin
    if (sx[SW-1]) begin
      mag_d = '0;
    end else if (sx > MAG_MAX) begin
      mag_d = MAG_MAX[DATA_W-1:0];
    end else begin
      mag_d = sx[DATA_W-1:0];
    end
    if (sy > RES_MAX) begin
      res_d = RES_MAX[DATA_W-1:0];
    end else if (sy < RES_MIN) begin
      res_d = RES_MIN[DATA_W-1:0];
    end else begin
      res_d = sy[DATA_W-1:0];
    end
  end

  logic               svalid_q;
  logic [PAY_W-1:0]   spay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svalid_q <= 1'b0;
    end else if (en) begin
      svalid_q <= mvalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      spay_q <= {mz_q, res_d, mag_d};
    end
  end

  // output register and skid buffer
  logic             out_valid_q;
  logic [PAY_W-1:0] out_pay_q, skid_pay_q;
  logic             take, leave;
  assign take  = out_valid_q && m_axis_tready;
  assign leave = en && svalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (leave) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_pay_q <= skid_pay_q;
      end
    end else if (leave) begin
      if (!out_valid_q || take) begin
        out_pay_q <= spay_q;
      end else begin
        skid_pay_q <= spay_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = BUS_W'(out_pay_q);

endmodule

`default_nettype wire
